// ===== rtl/magma_block_cipher_defines.svh =====
// ----------------------------------------------------------------------------
// magma_block_cipher_defines.svh
// Assertion macros for the Magma cipher RTL.
// ----------------------------------------------------------------------------
`ifndef MAGMA_BLOCK_CIPHER_DEFINES_SVH
`define MAGMA_BLOCK_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define MAGMA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("magma assertion failed");
// Next-cycle implication, checked out of reset
`define MAGMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("magma assertion failed");
`else
`define MAGMA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MAGMA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/magma_pkg.sv =====
// ----------------------------------------------------------------------------
// magma_pkg
// Shared types, constants and round functions for the Magma block cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package magma_pkg;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned RoundW    = $clog2(NumRounds);
  localparam int unsigned NumKeyRegs = 4;
  localparam int unsigned KeyIdxW   = $clog2(NumKeyRegs);
  localparam int unsigned AddrW     = KeyIdxW + 3;   // 8-byte register stride
  localparam int unsigned RotAmt    = 11;

  typedef logic [NumKeyRegs-1:0][63:0] key_t;

  // Controller to datapath command bundle
  typedef struct packed {
    logic              load;   // take a new block and run round 0 on it
    logic              step;   // run one round on the held state
    logic              last;   // this round is the final one
    logic [RoundW-1:0] round;  // round number 0..31
  } cmd_t;

  // S-box pi_k, k = nibble position (0 least significant)
  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
      4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
    '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
      4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
    '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
      4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
    '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
      4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
    '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
      4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
    '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
      4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
    '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
      4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
    '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
      4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
  };

  // Substitution layer: eight parallel 4-bit lookups
  function automatic logic [31:0] sbox_layer(input logic [31:0] x);
    logic [31:0] y;
    y = '0;
    for (int n = 0; n < 8; n++) begin
      y[4*n +: 4] = SBOX[n][x[4*n +: 4]];
    end
    return y;
  endfunction

  // Sub-key index (0 = K1) for a round; decrypt walks the schedule backwards
  function automatic logic [2:0] key_sel(input logic [RoundW-1:0] round,
                                         input logic dec);
    logic [RoundW-1:0] r;
    r = dec ? ~round : round;
    return (r[RoundW-1:RoundW-2] == 2'b11) ? ~r[2:0] : r[2:0];
  endfunction

endpackage

// ===== rtl/magma_ctrl.sv =====
// ----------------------------------------------------------------------------
// magma_ctrl
// Round sequencer: accepts a start, counts 32 rounds, strobes done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module magma_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  output magma_pkg::cmd_t cmd
);
  import magma_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state;
  logic              state_next;
  logic [RoundW-1:0] cnt;
  logic [RoundW-1:0] cnt_next;
  logic              last_round;

  assign busy       = (state == ST_RUN);
  assign last_round = (state == ST_RUN) && (cnt == RoundW'(NumRounds - 1));

  // Commands to the datapath
  always_comb begin
    cmd.load  = (state == ST_IDLE) && start;
    cmd.step  = (state == ST_RUN);
    cmd.last  = last_round;
    cmd.round = (state == ST_IDLE) ? '0 : cnt;
  end

  // Next state and round counter
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
          cnt_next   = RoundW'(1);   // round 0 runs at the accept edge
        end
      end
      ST_RUN: begin
        cnt_next = cnt + RoundW'(1);
        if (last_round) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= last_round;
    end
  end

endmodule

// ===== rtl/magma_dp.sv =====
// ----------------------------------------------------------------------------
// magma_dp
// Feistel datapath: one round unit, half-block registers, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module magma_dp (
  input  logic            clk,
  input  magma_pkg::cmd_t cmd,
  input  logic            func,
  input  logic [63:0]     data_block,
  input  magma_pkg::key_t key,
  output logic [63:0]     result_block
);
  import magma_pkg::*;

  logic [31:0] left;
  logic [31:0] right;
  logic        dec;

  logic [31:0] l_in;
  logic [31:0] r_in;
  logic        dec_in;
  logic [2:0]  ksel;
  logic [31:0] rkey;
  logic [31:0] sum;
  logic [31:0] sub;
  logic [31:0] mixed;

  // Round operands come from the ports on load, else from the held state
  assign l_in   = cmd.load ? data_block[63:32] : left;
  assign r_in   = cmd.load ? data_block[31:0]  : right;
  assign dec_in = cmd.load ? func : dec;

  // Round key: even index is the upper word of its key register
  assign ksel = key_sel(cmd.round, dec_in);
  assign rkey = ksel[0] ? key[ksel[2:1]][31:0] : key[ksel[2:1]][63:32];

  // Round function
  assign sum   = r_in + rkey;
  assign sub   = sbox_layer(sum);
  assign mixed = l_in ^ {sub[31-RotAmt:0], sub[31:32-RotAmt]};

  // State update; the result register takes the final round without the swap
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.step) begin
      left  <= r_in;
      right <= mixed;
      dec   <= dec_in;
    end
    if (cmd.last) begin
      result_block <= {mixed, r_in};
    end
  end

endmodule

// ===== rtl/magma_block_cipher.sv =====
// ----------------------------------------------------------------------------
// magma_block_cipher
// Magma (GOST 64-bit) block cipher with APB key registers.
// ----------------------------------------------------------------------------
// Usage:
//   Key: four 64-bit registers at byte addresses 0, 8, 16, 24 (key bytes
//   0-7, 8-15, 16-23, 24-31, lowest byte most significant). Write them
//   only while busy is low. Reads return the stored key words.
//   Command: drive func (0 encrypt, 1 decrypt) and data_block and raise
//   start; the transaction is taken at an edge where start is high and
//   busy is low. busy stays high until the final round has run.
//   Result: done is high for a single cycle, and result_block is valid from
//   then until the next block's final round; the receiver cannot stall it.
//   The single round unit runs one Feistel round per cycle and takes a
//   new block only after the last one is through. A new start is accepted in the
//   same cycle that done is shown.
//   Reset (rst, synchronous): clears the key registers to zero and
//   returns the sequencer to idle; any block in flight is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "magma_block_cipher_defines.svh"

module magma_block_cipher (
  input  logic                        clk,
  input  logic                        rst,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic                        func,
  input  logic [63:0]                 data_block,
  // result channel
  output logic                        done,
  output logic [63:0]                 result_block,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [magma_pkg::AddrW-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);
  import magma_pkg::*;

  key_t               key;
  cmd_t               cmd;
  logic [KeyIdxW-1:0] reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:3];
  assign wr_en   = psel && penable && pwrite && pready;
  assign prdata  = key[reg_idx];

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (wr_en) begin
      key[reg_idx] <= pwdata;
    end
  end

  magma_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  magma_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .func         (func),
    .data_block   (data_block),
    .key          (key),
    .result_block (result_block)
  );

  // Checks
  `MAGMA_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  `MAGMA_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `MAGMA_ASSERT_IMPL(a_done_after_run, clk, rst, done, $past(busy) && $past(cmd.last))

endmodule
